FILE: rtl/core/nemd_pkg.sv
// Shared types, codes and saturation helpers for the normalized
// energy-momentum deviation block. No dependencies.
package nemd_pkg;

	// Wide intermediate range of the datapath
	localparam int WIDE_W = 39;
	localparam int MAG_W  = 64;
	localparam int COEFS  = 3;

	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [31:0]       fx_t;

	localparam wide_t WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
	localparam wide_t WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
	localparam logic [MAG_W-1:0] WPOS_LIM = (64'd1 << (WIDE_W-1)) - 64'd1;
	localparam logic [MAG_W-1:0] WNEG_LIM = 64'd1 << (WIDE_W-1);
	localparam logic [MAG_W-1:0] NPOS_LIM = (64'd1 << 31) - 64'd1;
	localparam logic [MAG_W-1:0] NNEG_LIM = 64'd1 << 31;

	// Command codes
	localparam logic [2:0] CMD_CALC    = 3'd0;
	localparam logic [2:0] CMD_WR_MEAN = 3'd1;
	localparam logic [2:0] CMD_WR_SIG  = 3'd2;
	localparam logic [2:0] CMD_RD_MEAN = 3'd3;
	localparam logic [2:0] CMD_RD_SIG  = 3'd4;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_MOM  = 3'd1;
	localparam logic [2:0] ST_BAD_SEC  = 3'd2;
	localparam logic [2:0] ST_ZERO_SIG = 3'd3;
	localparam logic [2:0] ST_BAD_IDX  = 3'd4;

	// Per-item bookkeeping carried alongside the datapath
	typedef struct packed {
		logic       calc;
		logic [2:0] status;
		fx_t        rdval;
	} meta_t;

	// Coefficient write request
	typedef struct packed {
		logic       en;
		logic       kind;
		logic [4:0] row;
		logic [1:0] word;
		fx_t        data;
	} coef_wr_t;

	function automatic wide_t clamp_sum(input logic signed [WIDE_W:0] s);
		if (s[WIDE_W] != s[WIDE_W-1]) begin
			return s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
		end
		return s[WIDE_W-1:0];
	endfunction

	function automatic wide_t add_sat(input wide_t a, input wide_t b);
		logic signed [WIDE_W:0] s;
		s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
		return clamp_sum(s);
	endfunction

	function automatic wide_t sub_sat(input wide_t a, input wide_t b);
		logic signed [WIDE_W:0] s;
		s = {a[WIDE_W-1], a} - {b[WIDE_W-1], b};
		return clamp_sum(s);
	endfunction

	// Sign and magnitude to the wide range, saturating
	function automatic wide_t sat_mag_w(input logic neg, input logic [MAG_W-1:0] mag);
		if (!neg) begin
			return (mag > WPOS_LIM) ? WIDE_MAX : $signed(mag[WIDE_W-1:0]);
		end
		return (mag > WNEG_LIM) ? WIDE_MIN : -$signed(mag[WIDE_W-1:0]);
	endfunction

	// Sign and magnitude to 32 bits, saturating
	function automatic fx_t sat_mag_n(input logic neg, input logic [MAG_W-1:0] mag);
		if (!neg) begin
			return (mag > NPOS_LIM) ? 32'sh7fff_ffff : $signed(mag[31:0]);
		end
		return (mag > NNEG_LIM) ? 32'sh8000_0000 : -$signed(mag[31:0]);
	endfunction

endpackage

FILE: rtl/core/nemd_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one valid chain and payload. Depends on nemd_pkg.
module nemd_div #(
	parameter int LANES = 1,
	parameter int NW    = 55,
	parameter int DW    = 32,
	parameter int PW    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [nemd_pkg::WIDE_W-1:0] in_num [LANES],
	input  logic signed [DW-1:0]              in_den [LANES],
	input  logic [PW-1:0]                     in_pay,
	output logic                              out_valid,
	output logic [NW-1:0]                     out_mag [LANES],
	output logic                              out_neg [LANES],
	output logic [PW-1:0]                     out_pay
);
	localparam int WW = nemd_pkg::WIDE_W;
	localparam int SH = NW - WW;

	logic              vld_sk [NW+1];
	logic [PW-1:0]     pay_sk [NW+1];
	logic [NW-1:0]     num_sk [NW+1][LANES];
	logic [DW-1:0]     rem_sk [NW+1][LANES];
	logic [DW-1:0]     den_sk [NW+1][LANES];
	logic              neg_sk [NW+1][LANES];

	logic [WW-1:0]     nabs_c [LANES];
	logic [DW-1:0]     dabs_c [LANES];
	logic [DW:0]       sh_c   [NW][LANES];
	logic [DW:0]       df_c   [NW][LANES];
	logic              ge_c   [NW][LANES];

	// Take magnitudes at the entry
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			nabs_c[l] = in_num[l][WW-1] ? unsigned'(-in_num[l]) : unsigned'(in_num[l]);
			dabs_c[l] = in_den[l][DW-1] ? unsigned'(-in_den[l]) : unsigned'(in_den[l]);
		end
	end

	// Trial subtract for every stage
	always_comb begin
		for (int k = 0; k < NW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				sh_c[k][l] = {rem_sk[k][l], num_sk[k][l][NW-1]};
				df_c[k][l] = sh_c[k][l] - {1'b0, den_sk[k][l]};
				ge_c[k][l] = sh_c[k][l] >= {1'b0, den_sk[k][l]};
			end
		end
	end

	// Advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NW; k++) vld_sk[k] <= 1'b0;
		end else if (en) begin
			vld_sk[0] <= in_valid;
			for (int k = 0; k < NW; k++) vld_sk[k+1] <= vld_sk[k];
		end
	end

	// Advance the data; the numerator register collects quotient bits
	always_ff @(posedge clk) begin
		if (en) begin
			pay_sk[0] <= in_pay;
			for (int l = 0; l < LANES; l++) begin
				num_sk[0][l] <= {nabs_c[l], {SH{1'b0}}};
				rem_sk[0][l] <= '0;
				den_sk[0][l] <= dabs_c[l];
				neg_sk[0][l] <= in_num[l][WW-1] ^ in_den[l][DW-1];
			end
			for (int k = 0; k < NW; k++) begin
				pay_sk[k+1] <= pay_sk[k];
				for (int l = 0; l < LANES; l++) begin
					num_sk[k+1][l] <= {num_sk[k][l][NW-2:0], ge_c[k][l]};
					rem_sk[k+1][l] <= ge_c[k][l] ? df_c[k][l][DW-1:0] : sh_c[k][l][DW-1:0];
					den_sk[k+1][l] <= den_sk[k][l];
					neg_sk[k+1][l] <= neg_sk[k][l];
				end
			end
		end
	end

	always_comb begin
		out_valid = vld_sk[NW];
		out_pay   = pay_sk[NW];
		for (int l = 0; l < LANES; l++) begin
			out_mag[l] = num_sk[NW][l];
			out_neg[l] = neg_sk[NW][l];
		end
	end

endmodule

FILE: rtl/core/nemd_coef.sv
// Coefficient store: mean and sigma memories, one row per charge table and
// sector, with per-word valid bits. Depends on nemd_pkg.
module nemd_coef #(
	parameter int SECTORS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  nemd_pkg::coef_wr_t wr,
	input  logic [4:0]         rd_row,
	output nemd_pkg::fx_t      mean_w [nemd_pkg::COEFS],
	output nemd_pkg::fx_t      sig_w  [nemd_pkg::COEFS]
);
	localparam int NC   = nemd_pkg::COEFS;
	localparam int ROWS = 2 * SECTORS;
	localparam int RW   = $clog2(ROWS);

	nemd_pkg::fx_t  mean_mem [ROWS][NC];
	nemd_pkg::fx_t  sig_mem  [ROWS][NC];
	logic [NC-1:0]  mean_vld_q [ROWS];
	logic [NC-1:0]  sig_vld_q  [ROWS];

	nemd_pkg::fx_t  mean_rd_s1 [NC];
	nemd_pkg::fx_t  sig_rd_s1  [NC];
	logic [NC-1:0]  mean_rv_s1;
	logic [NC-1:0]  sig_rv_s1;

	logic [RW-1:0]  wrow;
	logic [RW-1:0]  rrow;

	assign wrow = wr.row[RW-1:0];
	assign rrow = rd_row[RW-1:0];

	// Write one word
	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.kind) begin
				sig_mem[wrow][wr.word] <= wr.data;
			end else begin
				mean_mem[wrow][wr.word] <= wr.data;
			end
		end
	end

	// Mark written words; reset clears the whole table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				mean_vld_q[r] <= '0;
				sig_vld_q[r]  <= '0;
			end
		end else if (wr.en) begin
			if (wr.kind) begin
				sig_vld_q[wrow][wr.word] <= 1'b1;
			end else begin
				mean_vld_q[wrow][wr.word] <= 1'b1;
			end
		end
	end

	// Read the selected row of both tables
	always_ff @(posedge clk) begin
		if (en) begin
			mean_rd_s1 <= mean_mem[rrow];
			sig_rd_s1  <= sig_mem[rrow];
			mean_rv_s1 <= mean_vld_q[rrow];
			sig_rv_s1  <= sig_vld_q[rrow];
		end
	end

	// Unwritten words read as zero
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			mean_w[i] = mean_rv_s1[i] ? mean_rd_s1[i] : '0;
			sig_w[i]  = sig_rv_s1[i] ? sig_rd_s1[i] : '0;
		end
	end

endmodule

FILE: rtl/core/normalized_energy_momentum_deviation_top.sv
// Top level of the normalized energy-momentum deviation block: coefficient
// store, three divider pipelines and the join stages between them.
// Depends on nemd_pkg, nemd_coef and nemd_div.
//
//  Channel | Dir | Payload
//  s_*     | in  | tuser: cmd; tdata: charge_sign, sector, momentum, energy,
//          |     |        coef_index, coef_value
//  m_*     | out | tuser: status; tdata: value
//
// One transaction is taken every cycle while the output is free or taken.
// Three chained restoring dividers each resolve one quotient bit per stage.
// Reset clears all valid bits and the coefficient table (through per-word
// valid flags), so s_tready is high as soon as reset is released.
// A stall on m_tready holds every stage in place; nothing is lost or repeated.
module normalized_energy_momentum_deviation_top #(
	parameter int SECTORS   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [1:0] charge_sign, [5:2] sector, [37:6] momentum, [69:38] energy,
	// [71:70] coef_index, [103:72] coef_value
	input  logic [103:0] s_tdata,
	// [2:0] cmd
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] value
	output logic [31:0]  m_tdata,
	// [2:0] status
	output logic [2:0]   m_tuser
);
	localparam int WW = nemd_pkg::WIDE_W;
	localparam int NC = nemd_pkg::COEFS;
	localparam int NW = WW + FRAC_BITS;
	localparam nemd_pkg::wide_t ONE_W = nemd_pkg::wide_t'(64'd1 << FRAC_BITS);
	localparam nemd_pkg::fx_t   ONE_N = nemd_pkg::fx_t'(64'd1 << FRAC_BITS);

	typedef struct packed {
		nemd_pkg::meta_t meta;
		nemd_pkg::fx_t   c0m;
		nemd_pkg::fx_t   c0s;
		nemd_pkg::fx_t   mom;
	} pay1_t;

	typedef struct packed {
		nemd_pkg::meta_t meta;
		nemd_pkg::wide_t d;
		nemd_pkg::wide_t am;
		nemd_pkg::wide_t as;
	} pay2_t;

	localparam int PW1 = $bits(pay1_t);
	localparam int PW2 = $bits(pay2_t);
	localparam int PW3 = $bits(nemd_pkg::meta_t);

	logic adv;
	logic acc;

	// Input fields
	logic [2:0]    in_cmd;
	logic [1:0]    in_chg;
	logic [3:0]    in_sec;
	nemd_pkg::fx_t in_mom;
	nemd_pkg::fx_t in_en;
	logic [1:0]    in_idx;
	nemd_pkg::fx_t in_cval;

	logic       pos0;
	logic       sec_ok0;
	logic       idx_ok0;
	logic [2:0] status0;
	logic [4:0] row0;
	nemd_pkg::coef_wr_t wr0;

	// Stage 1
	logic          vld_s1;
	logic [2:0]    cmd_s1;
	logic          pos_s1;
	logic          neg_s1;
	logic [1:0]    idx_s1;
	nemd_pkg::fx_t mom_s1;
	nemd_pkg::fx_t en_s1;
	logic [2:0]    status_s1;
	nemd_pkg::fx_t mean_w [NC];
	nemd_pkg::fx_t sig_w  [NC];
	nemd_pkg::fx_t mc [NC];
	nemd_pkg::fx_t sc [NC];
	nemd_pkg::fx_t rd_word;
	nemd_pkg::meta_t meta1;
	pay1_t         pay1;

	nemd_pkg::wide_t d1_num [5];
	nemd_pkg::fx_t   d1_den [5];
	logic            d1_vld;
	logic [NW-1:0]   d1_mag [5];
	logic            d1_neg [5];
	logic [PW1-1:0]  d1_pay;
	pay1_t           p1o;

	// Stage 2
	logic            vld_s2;
	nemd_pkg::meta_t meta_s2;
	nemd_pkg::wide_t d_s2;
	nemd_pkg::wide_t am_s2;
	nemd_pkg::wide_t as_s2;
	nemd_pkg::wide_t m2_s2;
	nemd_pkg::wide_t s2_s2;
	nemd_pkg::fx_t   mom_s2;
	pay2_t           pay2;

	nemd_pkg::wide_t d2_num [2];
	nemd_pkg::fx_t   d2_den [2];
	logic            d2_vld;
	logic [NW-1:0]   d2_mag [2];
	logic            d2_neg [2];
	logic [PW2-1:0]  d2_pay;
	pay2_t           p2o;

	// Stages 3 and 4
	logic            vld_s3;
	nemd_pkg::meta_t meta_s3;
	nemd_pkg::wide_t d_s3;
	nemd_pkg::wide_t off_s3;
	nemd_pkg::wide_t sig_s3;
	logic            vld_s4;
	nemd_pkg::meta_t meta_s4;
	nemd_pkg::meta_t meta4;
	nemd_pkg::wide_t diff_s4;
	nemd_pkg::wide_t sig_s4;

	nemd_pkg::wide_t d3_num [1];
	nemd_pkg::wide_t d3_den [1];
	logic            d3_vld;
	logic [NW-1:0]   d3_mag [1];
	logic            d3_neg [1];
	logic [PW3-1:0]  d3_pay;
	nemd_pkg::meta_t p3o;

	// Output register
	logic          out_vld_q;
	nemd_pkg::fx_t out_val_q;
	logic [2:0]    out_st_q;

	// Global advance: the whole pipeline moves when the output is free
	assign adv      = !out_vld_q || m_tready;
	assign acc      = s_tvalid && adv;
	assign s_tready = adv;

	// Unpack the transaction
	assign in_cmd  = s_tuser;
	assign in_chg  = s_tdata[1:0];
	assign in_sec  = s_tdata[5:2];
	assign in_mom  = s_tdata[37:6];
	assign in_en   = s_tdata[69:38];
	assign in_idx  = s_tdata[71:70];
	assign in_cval = s_tdata[103:72];

	assign pos0    = (in_chg == 2'b01);
	assign sec_ok0 = {1'b0, in_sec} < 5'(SECTORS);
	assign idx_ok0 = {1'b0, in_idx} < 3'(NC);
	assign row0    = sec_ok0 ? ((pos0 ? 5'(SECTORS) : 5'd0) + {1'b0, in_sec}) : 5'd0;

	// Early status
	always_comb begin
		if (in_cmd == nemd_pkg::CMD_CALC) begin
			priority if (in_mom[31] || in_mom == '0) status0 = nemd_pkg::ST_BAD_MOM;
			else if (!sec_ok0) status0 = nemd_pkg::ST_BAD_SEC;
			else status0 = nemd_pkg::ST_OK;
		end else if (in_cmd == nemd_pkg::CMD_WR_MEAN || in_cmd == nemd_pkg::CMD_WR_SIG ||
		             in_cmd == nemd_pkg::CMD_RD_MEAN || in_cmd == nemd_pkg::CMD_RD_SIG) begin
			priority if (!sec_ok0) status0 = nemd_pkg::ST_BAD_SEC;
			else if (!idx_ok0) status0 = nemd_pkg::ST_BAD_IDX;
			else status0 = nemd_pkg::ST_OK;
		end else begin
			status0 = nemd_pkg::ST_BAD_IDX;
		end
	end

	// Coefficient write request
	always_comb begin
		wr0.en   = acc && (in_cmd == nemd_pkg::CMD_WR_MEAN || in_cmd == nemd_pkg::CMD_WR_SIG) &&
		           status0 == nemd_pkg::ST_OK;
		wr0.kind = (in_cmd == nemd_pkg::CMD_WR_SIG);
		wr0.row  = row0;
		wr0.word = in_idx;
		wr0.data = in_cval;
	end

	nemd_coef #(.SECTORS(SECTORS)) u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.wr     (wr0),
		.rd_row (row0),
		.mean_w (mean_w),
		.sig_w  (sig_w)
	);

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1    <= in_cmd;
			pos_s1    <= pos0;
			neg_s1    <= in_chg[1];
			idx_s1    <= in_idx;
			mom_s1    <= in_mom;
			en_s1     <= in_en;
			status_s1 <= status0;
		end
	end

	// Pick coefficients; charge zero uses offset 0 and sigma 1
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			mc[i] = (pos_s1 || neg_s1) ? mean_w[i] : '0;
			sc[i] = (pos_s1 || neg_s1) ? sig_w[i] : ((i == 0) ? ONE_N : '0);
		end
	end

	// Read value
	always_comb begin
		rd_word = '0;
		if (status_s1 == nemd_pkg::ST_OK &&
		    (cmd_s1 == nemd_pkg::CMD_RD_MEAN || cmd_s1 == nemd_pkg::CMD_RD_SIG)) begin
			unique case (idx_s1)
				2'd0:    rd_word = (cmd_s1 == nemd_pkg::CMD_RD_MEAN) ? mean_w[0] : sig_w[0];
				2'd1:    rd_word = (cmd_s1 == nemd_pkg::CMD_RD_MEAN) ? mean_w[1] : sig_w[1];
				2'd2:    rd_word = (cmd_s1 == nemd_pkg::CMD_RD_MEAN) ? mean_w[2] : sig_w[2];
				default: rd_word = '0;
			endcase
		end
	end

	always_comb begin
		meta1.calc   = (cmd_s1 == nemd_pkg::CMD_CALC) && (status_s1 == nemd_pkg::ST_OK);
		meta1.status = status_s1;
		meta1.rdval  = rd_word;
		pay1.meta    = meta1;
		pay1.c0m     = mc[0];
		pay1.c0s     = sc[0];
		pay1.mom     = mom_s1;
		d1_num[0]    = nemd_pkg::wide_t'(en_s1);
		d1_num[1]    = nemd_pkg::wide_t'(mc[1]);
		d1_num[2]    = nemd_pkg::wide_t'(mc[2]);
		d1_num[3]    = nemd_pkg::wide_t'(sc[1]);
		d1_num[4]    = nemd_pkg::wide_t'(sc[2]);
		for (int l = 0; l < 5; l++) d1_den[l] = mom_s1;
	end

	// First divisions: e/p, c1/p and c2/p for both polynomials
	nemd_div #(.LANES(5), .NW(NW), .DW(32), .PW(PW1)) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s1),
		.in_num    (d1_num),
		.in_den    (d1_den),
		.in_pay    (pay1),
		.out_valid (d1_vld),
		.out_mag   (d1_mag),
		.out_neg   (d1_neg),
		.out_pay   (d1_pay)
	);

	assign p1o = d1_pay;

	// Stage 2: ratio minus one, first partial sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= p1o.meta;
			mom_s2  <= p1o.mom;
			d_s2    <= nemd_pkg::sub_sat(
				nemd_pkg::sat_mag_w(d1_neg[0], 64'(d1_mag[0])), ONE_W);
			am_s2   <= nemd_pkg::add_sat(nemd_pkg::wide_t'(p1o.c0m),
				nemd_pkg::sat_mag_w(d1_neg[1], 64'(d1_mag[1])));
			as_s2   <= nemd_pkg::add_sat(nemd_pkg::wide_t'(p1o.c0s),
				nemd_pkg::sat_mag_w(d1_neg[3], 64'(d1_mag[3])));
			m2_s2   <= nemd_pkg::sat_mag_w(d1_neg[2], 64'(d1_mag[2]));
			s2_s2   <= nemd_pkg::sat_mag_w(d1_neg[4], 64'(d1_mag[4]));
		end
	end

	always_comb begin
		pay2.meta = meta_s2;
		pay2.d    = d_s2;
		pay2.am   = am_s2;
		pay2.as   = as_s2;
		d2_num[0] = m2_s2;
		d2_num[1] = s2_s2;
		d2_den[0] = mom_s2;
		d2_den[1] = mom_s2;
	end

	// Second divisions: (c2/p)/p for both polynomials
	nemd_div #(.LANES(2), .NW(NW), .DW(32), .PW(PW2)) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.in_num    (d2_num),
		.in_den    (d2_den),
		.in_pay    (pay2),
		.out_valid (d2_vld),
		.out_mag   (d2_mag),
		.out_neg   (d2_neg),
		.out_pay   (d2_pay)
	);

	assign p2o = d2_pay;

	// Stage 3: finish offset and sigma
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= d2_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= p2o.meta;
			d_s3    <= p2o.d;
			off_s3  <= nemd_pkg::add_sat(p2o.am,
				nemd_pkg::sat_mag_w(d2_neg[0], 64'(d2_mag[0])));
			sig_s3  <= nemd_pkg::add_sat(p2o.as,
				nemd_pkg::sat_mag_w(d2_neg[1], 64'(d2_mag[1])));
		end
	end

	// Stage 4: deviation and zero-sigma check
	always_comb begin
		meta4 = meta_s3;
		if (meta_s3.calc && sig_s3 == '0) begin
			meta4.calc   = 1'b0;
			meta4.status = nemd_pkg::ST_ZERO_SIG;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s4 <= meta4;
			diff_s4 <= nemd_pkg::sub_sat(d_s3, off_s3);
			sig_s4  <= sig_s3;
		end
	end

	assign d3_num[0] = diff_s4;
	assign d3_den[0] = sig_s4;

	// Final division by sigma
	nemd_div #(.LANES(1), .NW(NW), .DW(WW), .PW(PW3)) u_div3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s4),
		.in_num    (d3_num),
		.in_den    (d3_den),
		.in_pay    (meta_s4),
		.out_valid (d3_vld),
		.out_mag   (d3_mag),
		.out_neg   (d3_neg),
		.out_pay   (d3_pay)
	);

	assign p3o = d3_pay;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= d3_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_val_q <= p3o.calc ? nemd_pkg::sat_mag_n(d3_neg[0], 64'(d3_mag[0])) : p3o.rdval;
			out_st_q  <= p3o.status;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_val_q;
	assign m_tuser  = out_st_q;

	// Every error status carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != nemd_pkg::ST_OK |-> m_tdata == '0)
		else $error("error status with nonzero value");

	// Zero-sigma status is only raised on a zero sigma
	a_zero_sig: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && meta_s4.status == nemd_pkg::ST_ZERO_SIG |-> sig_s4 == '0)
		else $error("zero-sigma status without zero sigma");

	// Table writes only for good write commands
	a_wr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		wr0.en |-> s_tready && status0 == nemd_pkg::ST_OK && !in_cmd[2])
		else $error("table write outside a good write transaction");

endmodule
